// ===== design/baf_pkg.sv =====
// Shared constants, types and the reciprocal table of the box average filter.
`default_nettype none

package baf_pkg;

  // Window and frame limits
  localparam int MaxRadius = 4;
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int LineRows  = 2 * MaxRadius;
  localparam int MaxSide   = LineRows + 1;

  // Field widths
  localparam int RadW    = 3;
  localparam int WidthW  = 11;
  localparam int HeightW = 13;
  localparam int RowW    = 12;
  localparam int ColW    = 10;
  localparam int PixW    = 8;

  // Derived arithmetic widths
  localparam int LinesW    = $clog2(LineRows + 1);
  localparam int SideW     = $clog2(MaxSide + 1);
  localparam int CsW       = $clog2(MaxSide * 255 + 1);
  localparam int SumW      = $clog2(MaxSide * MaxSide * 255 + 1);
  localparam int RecipFrac = 24;
  localparam int RecipW    = RecipFrac + 1;
  localparam int ProdW     = SumW + RecipW;

  // Queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Register port
  localparam int AddrW = 4;
  localparam int DataW = 32;

  localparam logic [RadW-1:0]    RadiusRst = 3'd1;
  localparam logic [WidthW-1:0]  WidthRst  = 11'd640;
  localparam logic [HeightW-1:0] HeightRst = 13'd480;

  typedef enum logic [1:0] {
    RegRadius = 2'd0,
    RegWidth  = 2'd1,
    RegHeight = 2'd2
  } reg_idx_t;

  // Clamped configuration as seen by the datapath
  typedef struct packed {
    logic [RadW-1:0]    radius;
    logic [WidthW-1:0]  width;
    logic [HeightW-1:0] height;
  } cfg_t;

  // One classified pixel on its way from front to back
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic [ColW-1:0] col;
    logic            emit;
    logic [RowW-1:0] out_row;
    logic [ColW-1:0] out_col;
  } item_t;

  // ceil(2^24 / side^2); exact floor division for every window sum
  function automatic logic [RecipW-1:0] recip(input logic [RadW-1:0] r);
    logic [RecipW-1:0] m;
    case (r)
      3'd0:    m = 25'd16777216;
      3'd1:    m = 25'd1864136;
      3'd2:    m = 25'd671089;
      3'd3:    m = 25'd342393;
      default: m = 25'd207127;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== design/baf_if.sv =====
// Pixel and result channel interfaces of the box average filter.
`default_nettype none

interface baf_in_if;
  logic                      valid;
  logic                      ready;
  logic [baf_pkg::PixW-1:0]  pixel;
  logic                      frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface baf_out_if;
  logic                      valid;
  logic                      ready;
  logic [baf_pkg::RowW-1:0]  center_row;
  logic [baf_pkg::ColW-1:0]  center_col;
  logic [baf_pkg::PixW-1:0]  average;

  modport source (output valid, output center_row, output center_col, output average,
                  input ready);
  modport sink   (input valid, input center_row, input center_col, input average,
                  output ready);
endinterface

`default_nettype wire

// ===== design/baf_cfg.sv =====
// Register file of the box average filter with range clamping.
`default_nettype none

module baf_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [baf_pkg::AddrW-1:0]   paddr,
  input  wire logic [baf_pkg::DataW-1:0]   pwdata,
  output logic      [baf_pkg::DataW-1:0]   prdata,
  output logic                             pready,
  output baf_pkg::cfg_t                    cfg
);

  logic [baf_pkg::RadW-1:0]    radius_r,    radius_nxt;
  logic [baf_pkg::WidthW-1:0]  width_r,     width_nxt;
  logic [baf_pkg::HeightW-1:0] height_r,    height_nxt;
  baf_pkg::reg_idx_t           idx;
  logic                        wr_en;

  always_comb begin
    idx        = baf_pkg::reg_idx_t'(paddr[baf_pkg::AddrW-1:2]);
    pready     = 1'b1;
    wr_en      = psel && penable && pwrite && pready;
    radius_nxt = radius_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (idx)
        baf_pkg::RegRadius: radius_nxt = pwdata[baf_pkg::RadW-1:0];
        baf_pkg::RegWidth:  width_nxt  = pwdata[baf_pkg::WidthW-1:0];
        baf_pkg::RegHeight: height_nxt = pwdata[baf_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      baf_pkg::RegRadius: prdata = baf_pkg::DataW'(radius_r);
      baf_pkg::RegWidth:  prdata = baf_pkg::DataW'(width_r);
      baf_pkg::RegHeight: prdata = baf_pkg::DataW'(height_r);
      default:            prdata = '0;
    endcase
  end

  // Clamp to the supported ranges
  always_comb begin
    cfg.radius = (radius_r > baf_pkg::RadW'(baf_pkg::MaxRadius)) ?
                 baf_pkg::RadW'(baf_pkg::MaxRadius) : radius_r;
    if (width_r == '0) begin
      cfg.width = baf_pkg::WidthW'(1);
    end else if (width_r > baf_pkg::WidthW'(baf_pkg::MaxWidth)) begin
      cfg.width = baf_pkg::WidthW'(baf_pkg::MaxWidth);
    end else begin
      cfg.width = width_r;
    end
    if (height_r == '0) begin
      cfg.height = baf_pkg::HeightW'(1);
    end else if (height_r > baf_pkg::HeightW'(baf_pkg::MaxHeight)) begin
      cfg.height = baf_pkg::HeightW'(baf_pkg::MaxHeight);
    end else begin
      cfg.height = height_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= baf_pkg::RadiusRst;
      width_r  <= baf_pkg::WidthRst;
      height_r <= baf_pkg::HeightRst;
    end else begin
      radius_r <= radius_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/baf_front.sv =====
// Front end: tracks raster position, drops pixels past frame end, classifies the rest.
`default_nettype none

module baf_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  baf_in_if.sink             in_chan,
  input  baf_pkg::cfg_t      cfg,
  input  wire logic          q_full,
  output logic               push,
  output baf_pkg::item_t     push_item
);

  logic [baf_pkg::RowW-1:0]   row_r, row_nxt, row;
  logic [baf_pkg::ColW-1:0]   col_r, col_nxt, col, c;
  logic                       done_r, done_nxt, done;
  logic                       fire;
  logic [baf_pkg::LinesW-1:0] lines;
  logic                       end_of_row;
  logic                       last_row;

  always_comb begin
    in_chan.ready = !q_full;
    fire          = in_chan.valid && in_chan.ready;

    // frame_start rewinds the position before the pixel is taken
    row  = in_chan.frame_start ? '0 : row_r;
    col  = in_chan.frame_start ? '0 : col_r;
    done = in_chan.frame_start ? 1'b0 : done_r;

    lines = {cfg.radius, 1'b0};
    c     = ({1'b0, col} >= cfg.width) ?
            baf_pkg::ColW'(cfg.width - baf_pkg::WidthW'(1)) : col;

    end_of_row = ({1'b0, c} + baf_pkg::WidthW'(1)) >= cfg.width;
    last_row   = ({1'b0, row} + baf_pkg::HeightW'(1)) >= cfg.height;

    push_item.pixel   = in_chan.pixel;
    push_item.col     = c;
    push_item.emit    = (row >= baf_pkg::RowW'(lines)) && (c >= baf_pkg::ColW'(lines));
    push_item.out_row = row - baf_pkg::RowW'(cfg.radius);
    push_item.out_col = c - baf_pkg::ColW'(cfg.radius);

    push     = 1'b0;
    row_nxt  = row_r;
    col_nxt  = col_r;
    done_nxt = done_r;
    if (fire) begin
      row_nxt  = row;
      col_nxt  = col;
      done_nxt = done;
      if (!done) begin
        push = 1'b1;
        if (end_of_row) begin
          if (last_row) begin
            done_nxt = 1'b1;
            col_nxt  = c;
          end else begin
            col_nxt = '0;
            row_nxt = row + baf_pkg::RowW'(1);
          end
        end else begin
          col_nxt = c + baf_pkg::ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      done_r <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/baf_queue.sv =====
// Short FIFO that decouples the front end from the filter back end.
`default_nettype none

module baf_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  baf_pkg::item_t     push_item,
  output logic               full,
  input  wire logic          pop,
  output baf_pkg::item_t     head,
  output logic               empty
);

  baf_pkg::item_t              entries_r [baf_pkg::QDepth];
  logic [baf_pkg::QPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [baf_pkg::QPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [baf_pkg::QCntW-1:0]   count_r, count_nxt;

  always_comb begin
    full       = count_r == baf_pkg::QCntW'(baf_pkg::QDepth);
    empty      = count_r == '0;
    head       = entries_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + baf_pkg::QPtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + baf_pkg::QPtrW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + baf_pkg::QCntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - baf_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

// ===== design/baf_back.sv =====
// Back end: line store update, column sums, window sum, divide and output register.
`default_nettype none

module baf_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  baf_pkg::cfg_t      cfg,
  input  wire logic          q_empty,
  input  baf_pkg::item_t     q_head,
  output logic               q_pop,
  baf_out_if.source          out_chan
);

  typedef logic [baf_pkg::LineRows-1:0][baf_pkg::PixW-1:0] line_word_t;

  // Line store: one word per column, one byte per stored row
  line_word_t line_mem [baf_pkg::MaxWidth];
  line_word_t rdata_r;
  line_word_t fwd_data_r;
  line_word_t old_word;
  line_word_t new_word;
  logic       fwd_r;

  baf_pkg::item_t s1_r;
  logic           s1_valid_r;

  // Column-sum window
  logic [baf_pkg::MaxSide-1:0][baf_pkg::CsW-1:0] win_r, win_nxt;
  logic [baf_pkg::CsW-1:0]                       cs;

  logic                       s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic [baf_pkg::RowW-1:0]   s2_row_r, s3_row_r, s4_row_r, out_row_r;
  logic [baf_pkg::ColW-1:0]   s2_col_r, s3_col_r, s4_col_r, out_col_r;
  logic [baf_pkg::SumW-1:0]   sum, sum_r;
  logic [baf_pkg::ProdW-1:0]  prod, prod_r;
  logic [baf_pkg::PixW-1:0]   avg_r;

  logic                       adv;
  logic [baf_pkg::LinesW-1:0] lines;
  logic [baf_pkg::SideW-1:0]  side;

  always_comb begin
    adv   = !out_valid_r || out_chan.ready;
    q_pop = adv && !q_empty;
    lines = {cfg.radius, 1'b0};
    side  = baf_pkg::SideW'(lines) + baf_pkg::SideW'(1);
  end

  // Gather the column, rotate the stored rows up, form the column sum
  always_comb begin
    old_word = fwd_r ? fwd_data_r : rdata_r;
    cs       = baf_pkg::CsW'(s1_r.pixel);
    new_word = old_word;
    for (int k = 0; k < baf_pkg::LineRows; k++) begin
      if (baf_pkg::LinesW'(k) < lines) begin
        cs = cs + baf_pkg::CsW'(old_word[k]);
      end
      if (baf_pkg::LinesW'(k + 1) == lines) begin
        new_word[k] = s1_r.pixel;
      end
    end
    for (int k = 0; k < baf_pkg::LineRows - 1; k++) begin
      if (baf_pkg::LinesW'(k + 1) < lines) begin
        new_word[k] = old_word[k + 1];
      end
    end
  end

  // Shift the window left, insert the new column on the right
  always_comb begin
    win_nxt = win_r;
    if (s1_valid_r) begin
      for (int j = 0; j < baf_pkg::MaxSide - 1; j++) begin
        if (baf_pkg::SideW'(j + 1) < side) begin
          win_nxt[j] = win_r[j + 1];
        end
      end
      for (int j = 0; j < baf_pkg::MaxSide; j++) begin
        if (baf_pkg::SideW'(j + 1) == side) begin
          win_nxt[j] = cs;
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int j = 0; j < baf_pkg::MaxSide; j++) begin
      if (baf_pkg::SideW'(j) < side) begin
        sum = sum + baf_pkg::SumW'(win_r[j]);
      end
    end
    prod = sum_r * baf_pkg::recip(cfg.radius);
  end

  // Line store: registered read of the next column, write-back of the current one
  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r <= line_mem[q_head.col];
      if (s1_valid_r) begin
        line_mem[s1_r.col] <= new_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r       <= q_head;
      fwd_data_r <= new_word;
      win_r      <= win_nxt;
      s2_row_r   <= s1_r.out_row;
      s2_col_r   <= s1_r.out_col;
      sum_r      <= sum;
      s3_row_r   <= s2_row_r;
      s3_col_r   <= s2_col_r;
      prod_r     <= prod;
      s4_row_r   <= s3_row_r;
      s4_col_r   <= s3_col_r;
      avg_r      <= prod_r[baf_pkg::RecipFrac +: baf_pkg::PixW];
      out_row_r  <= s4_row_r;
      out_col_r  <= s4_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= !q_empty;
      s2_valid_r  <= s1_valid_r && s1_r.emit;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
      // read of a column being written in the same cycle returns stale data
      fwd_r       <= !q_empty && s1_valid_r && (q_head.col == s1_r.col);
    end
  end

  always_comb begin
    out_chan.valid      = out_valid_r;
    out_chan.center_row = out_row_r;
    out_chan.center_col = out_col_r;
    out_chan.average    = avg_r;
  end

`ifndef ASSERT_OFF
  a_fwd_has_writer: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> $past(s1_valid_r))
    else $error("forwarded line word without a write-back");

  a_emit_enters_sum: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_valid_r && s1_r.emit |=> s2_valid_r)
    else $error("emitting pixel lost before window sum");

  a_sum_to_mult: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s2_valid_r |=> s3_valid_r)
    else $error("window sum lost before divide");
`endif

endmodule

`default_nettype wire

// ===== design/box_average_filter_top.sv =====
// Top level of the streaming box average filter.
// Usage:
//   in_chan carries grey pixels in raster order; frame_start marks the first
//   pixel of a frame and rewinds the position to row 0, column 0. Pixels that
//   arrive after the last pixel of a frame are dropped until the next
//   frame_start. out_chan carries one transaction per interior centre: its
//   row, column and the floor of the (2r+1)x(2r+1) window mean. Border centres
//   are never sent. The register port sets radius (0x0), width (0x4) and
//   height (0x8); write it only while the block is idle.
// Timing:
//   One pixel per clock sustained while out_chan is ready. Results pass
//   through queue, line store read, window update, window sum, divide by
//   a reciprocal multiply, output register. On each advance the line store
//   reads one column and writes back the previous; a repeated one is forwarded.
// Stall and reset:
//   A stalled receiver holds the output register and freezes the back end;
//   a four-entry queue keeps accepting pixels until it fills, then in_chan
//   ready drops. Reset restores the register defaults and the raster
//   position and empties the pipeline; line store contents are left as is.
`default_nettype none

module box_average_filter_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  baf_in_if.sink                           in_chan,
  baf_out_if.source                        out_chan,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [baf_pkg::AddrW-1:0]   paddr,
  input  wire logic [baf_pkg::DataW-1:0]   pwdata,
  output logic      [baf_pkg::DataW-1:0]   prdata,
  output logic                             pready
);

  baf_pkg::cfg_t  cfg;
  baf_pkg::item_t push_item;
  baf_pkg::item_t q_head;
  logic           push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  // Registers and range clamping
  baf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Accept, track position, drop past frame end, classify
  baf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Decouple front and back so each can stall alone
  baf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Line stores, window, mean and output register
  baf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
